FILE: hdl/tfc_pkg.sv
package tfc_pkg;

  // Source encodings held in the source_kind register
  localparam logic [1:0] KIND_F32  = 2'd0;
  localparam logic [1:0] KIND_F16  = 2'd1;
  localparam logic [1:0] KIND_BYTE = 2'd2;
  localparam logic [1:0] KIND_U32  = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_SOURCE_KIND   = 3'd0;
  localparam logic [2:0] REG_CHANNEL_COUNT = 3'd1;
  localparam logic [2:0] REG_SWAP_ORDER    = 3'd2;
  localparam logic [2:0] REG_DEPTH_MODE    = 3'd3;
  localparam logic [2:0] REG_PASS_THROUGH  = 3'd4;

  localparam int          LANES       = 4;
  localparam logic [15:0] SCALE_U8    = 16'h00FF;
  localparam logic [15:0] SCALE_U16   = 16'hFFFF;
  localparam logic [31:0] UNORM8_MAX  = 32'd255;
  localparam logic [31:0] UNORM16_MAX = 32'd65535;

  // What one lane does with its channel word
  typedef enum logic [2:0] {
    OP_ZERO,
    OP_COPY,
    OP_BYTE,
    OP_F32,
    OP_F16,
    OP_U32
  } lane_op_t;

  typedef struct packed {
    lane_op_t op;
    logic     wide;   // 1: unorm16 scale, 0: unorm8 scale
  } lane_ctrl_t;

  typedef enum logic [1:0] {
    RES_VAL,   // result is the stored value
    RES_SAT,   // input at or above 1.0
    RES_CONV   // scale mant * 2^-shift and floor
  } res_kind_t;

  typedef struct packed {
    res_kind_t   kind;
    logic [31:0] val;
    logic [23:0] mant;
    logic [7:0]  shift;
    logic        wide;
  } lane_dec_t;

endpackage

FILE: hdl/tfc_lane.sv
module tfc_lane
  import tfc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] word,
  input  lane_ctrl_t  ctrl,
  output logic [31:0] result
);

  lane_dec_t   dec;
  lane_dec_t   dec_r;
  logic [39:0] prod;
  res_kind_t   kind2;
  logic [31:0] val2;
  logic [7:0]  shift2;
  logic        wide2;

  // decode
  logic        f_sgn;
  logic [7:0]  f_exp;
  logic [22:0] f_frac;
  logic        h_sgn;
  logic [4:0]  h_exp;
  logic [9:0]  h_man;
  logic [3:0]  h_lead;
  logic [4:0]  u_lead;
  logic [31:0] u_norm;
  logic        u_rnd;
  logic [24:0] u_keep;
  logic [5:0]  u_pos;

  assign f_sgn  = word[31];
  assign f_exp  = word[30:23];
  assign f_frac = word[22:0];
  assign h_sgn  = word[15];
  assign h_exp  = word[14:10];
  assign h_man  = word[9:0];

  always_comb begin
    h_lead = '0;
    for (int i = 0; i < 10; i++) begin
      if (h_man[i]) h_lead = 4'(i);
    end
    u_lead = '0;
    for (int i = 0; i < 32; i++) begin
      if (word[i]) u_lead = 5'(i);
    end
  end

  // round the integer to 24 significant bits, ties to even
  always_comb begin
    u_norm = word << (5'd31 - u_lead);
    u_rnd  = u_norm[7] & ((|u_norm[6:0]) | u_norm[8]);
    u_keep = {1'b0, u_norm[31:8]} + 25'(u_rnd);
    u_pos  = {1'b0, u_lead} + 6'(u_keep[24]);
  end

  always_comb begin
    dec      = '0;
    dec.kind = RES_VAL;
    dec.wide = ctrl.wide;
    case (ctrl.op)
      OP_COPY: dec.val = word;
      OP_BYTE: dec.val = {24'd0, word[7:0]};
      OP_F32: begin
        if (f_exp == 8'hFF) begin
          if (f_frac == '0 && !f_sgn) dec.kind = RES_SAT;
        end else if (f_sgn || f_exp == '0) begin
          dec.kind = RES_VAL;
        end else if (f_exp >= 8'd127) begin
          dec.kind = RES_SAT;
        end else begin
          dec.kind  = RES_CONV;
          dec.mant  = {1'b1, f_frac};
          dec.shift = 8'd150 - f_exp;
        end
      end
      OP_F16: begin
        if (h_exp == 5'h1F) begin
          if (h_man == '0 && !h_sgn) dec.kind = RES_SAT;
        end else if (h_sgn || (h_exp == '0 && h_man == '0)) begin
          dec.kind = RES_VAL;
        end else if (h_exp == '0) begin
          dec.kind  = RES_CONV;
          dec.mant  = 24'(h_man) << (5'd23 - 5'(h_lead));
          dec.shift = 8'd47 - 8'(h_lead);
        end else if (h_exp >= 5'd15) begin
          dec.kind = RES_SAT;
        end else begin
          dec.kind  = RES_CONV;
          dec.mant  = {1'b1, h_man, 13'd0};
          dec.shift = 8'd38 - 8'(h_exp);
        end
      end
      OP_U32: begin
        if (word != '0) begin
          if (u_pos == 6'd32) begin
            dec.kind = RES_SAT;
          end else begin
            dec.kind  = RES_CONV;
            dec.mant  = u_keep[24] ? 24'h800000 : u_keep[23:0];
            dec.shift = 8'd55 - 8'(u_pos);
          end
        end
      end
      default: dec.val = '0;
    endcase
  end

  // decode register, then product register
  always_ff @(posedge clk) begin
    if (en) begin
      dec_r  <= dec;
      prod   <= 40'(dec_r.mant) * 40'(dec_r.wide ? SCALE_U16 : SCALE_U8);
      kind2  <= dec_r.kind;
      val2   <= dec_r.val;
      shift2 <= dec_r.shift;
      wide2  <= dec_r.wide;
    end
  end

  // round the product to float32 precision, then floor
  logic [5:0]  p_lead;
  logic [39:0] p_norm;
  logic        p_rnd;
  logic [24:0] p_q;
  logic [8:0]  p_sh;

  always_comb begin
    if (wide2) p_lead = prod[39] ? 6'd39 : 6'd38;
    else       p_lead = prod[31] ? 6'd31 : 6'd30;
    p_norm = prod << (6'd39 - p_lead);
    p_rnd  = p_norm[15] & ((|p_norm[14:0]) | p_norm[16]);
    p_q    = {1'b0, p_norm[39:16]} + 25'(p_rnd);
    p_sh   = {1'b0, shift2} + 9'd23 - 9'(p_lead);
    case (kind2)
      RES_SAT:  result = wide2 ? UNORM16_MAX : UNORM8_MAX;
      RES_CONV: result = (p_sh >= 9'd25) ? 32'd0 : 32'(p_q >> p_sh);
      default:  result = val2;
    endcase
  end

endmodule

FILE: hdl/tfc_merge.sv
module tfc_merge
  import tfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load_valid,
  input  logic [31:0] res_a,
  input  logic [31:0] res_b,
  input  logic [31:0] res_c,
  input  logic [31:0] res_d,
  input  logic        last,
  output logic        advance,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] out_a,
  output logic [31:0] out_b,
  output logic [31:0] out_c,
  output logic [31:0] out_d,
  output logic        last_out
);

  // the whole pipe moves when this register is empty or being drained
  assign advance = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_a    <= res_a;
      out_b    <= res_b;
      out_c    <= res_c;
      out_d    <= res_d;
      last_out <= last;
    end
  end

endmodule

FILE: hdl/texel_format_converter.sv
// Texel format converter.
// Input channel: one texel word per handshake on texel_valid/texel_ready,
// carrying chan_a..chan_d and last_in. Output channel: one converted word
// per handshake on result_valid/result_ready with out_a..out_d, last_out.
// Four identical lanes convert the four channels side by side; a merge
// stage collects the lane results into the output register.
// Each lane registers its decode and then its product; round and floor
// feed the merge stage's output register, which a word reaches after the
// decode and product registers, and one word per cycle is taken
// while the output keeps draining.
// The pipe moves as one: when the output register holds a word that the
// receiver does not take, every stage holds and texel_ready drops.
// Configuration goes through the APB-style port at byte addresses
// 0, 4, 8, 12, 16 (source_kind, channel_count, swap_order, depth_mode,
// pass_through); write it only while the block is idle.
// Reset clears the pipe valid bits and loads the register reset values
// (channel_count 4, all others 0).
module texel_format_converter
  import tfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        texel_valid,
  output logic        texel_ready,
  input  logic [31:0] chan_a,
  input  logic [31:0] chan_b,
  input  logic [31:0] chan_c,
  input  logic [31:0] chan_d,
  input  logic        last_in,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] out_a,
  output logic [31:0] out_b,
  output logic [31:0] out_c,
  output logic [31:0] out_d,
  output logic        last_out
);

  logic [1:0] source_kind;
  logic [2:0] channel_count;
  logic       swap_order;
  logic       depth_mode;
  logic       pass_through;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_kind   <= KIND_F32;
      channel_count <= 3'd4;
      swap_order    <= 1'b0;
      depth_mode    <= 1'b0;
      pass_through  <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_SOURCE_KIND:   source_kind   <= pwdata[1:0];
        REG_CHANNEL_COUNT: channel_count <= pwdata[2:0];
        REG_SWAP_ORDER:    swap_order    <= pwdata[0];
        REG_DEPTH_MODE:    depth_mode    <= pwdata[0];
        REG_PASS_THROUGH:  pass_through  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SOURCE_KIND:   prdata = {30'd0, source_kind};
      REG_CHANNEL_COUNT: prdata = {29'd0, channel_count};
      REG_SWAP_ORDER:    prdata = {31'd0, swap_order};
      REG_DEPTH_MODE:    prdata = {31'd0, depth_mode};
      REG_PASS_THROUGH:  prdata = {31'd0, pass_through};
      default:           prdata = '0;
    endcase
  end

  // Lane setup: clamp the channel count, route the words, pick each op
  logic [2:0]        n_chan;
  logic              do_swap;
  logic [31:0]       src   [LANES];
  lane_ctrl_t        ctrl  [LANES];
  logic [31:0]       res   [LANES];

  always_comb begin
    if (channel_count == 3'd0)     n_chan = 3'd1;
    else if (channel_count > 3'd4) n_chan = 3'd4;
    else                           n_chan = channel_count;
    // swap first and third only in color mode with three or more channels
    do_swap = swap_order && !pass_through && !depth_mode && (n_chan >= 3'd3);
    src[0] = do_swap ? chan_c : chan_a;
    src[1] = chan_b;
    src[2] = do_swap ? chan_a : chan_c;
    src[3] = chan_d;
    for (int i = 0; i < LANES; i++) begin
      ctrl[i].wide = depth_mode && !pass_through;
      ctrl[i].op   = OP_ZERO;
      if (pass_through) begin
        if (3'(i) < n_chan) ctrl[i].op = OP_COPY;
      end else if (depth_mode) begin
        if (i == 0) begin
          if (source_kind == KIND_F32)      ctrl[i].op = OP_F32;
          else if (source_kind == KIND_U32) ctrl[i].op = OP_U32;
        end
      end else if (3'(i) < n_chan) begin
        case (source_kind)
          KIND_F32:  ctrl[i].op = OP_F32;
          KIND_F16:  ctrl[i].op = OP_F16;
          KIND_BYTE: ctrl[i].op = OP_BYTE;
          default:   ctrl[i].op = OP_ZERO;
        endcase
      end
    end
  end

  // Pipe control: valid and last follow the two lane register steps
  logic advance;
  logic v1, v2;
  logic last1, last2;

  assign texel_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (advance) begin
      v1 <= texel_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      last1 <= last_in;
      last2 <= last1;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tfc_lane u_lane (
      .clk    (clk),
      .en     (advance),
      .word   (src[g]),
      .ctrl   (ctrl[g]),
      .result (res[g])
    );
  end

  tfc_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load_valid   (v2),
    .res_a        (res[0]),
    .res_b        (res[1]),
    .res_c        (res[2]),
    .res_d        (res[3]),
    .last         (last2),
    .advance      (advance),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_a        (out_a),
    .out_b        (out_b),
    .out_c        (out_c),
    .out_d        (out_d),
    .last_out     (last_out)
  );

endmodule

FILE: tb/sv/tfc_checker.sv
`timescale 1ns / 100ps

module tfc_checker
  import tfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        texel_valid,
  input  logic        texel_ready,
  input  logic [31:0] chan_a,
  input  logic [31:0] chan_b,
  input  logic [31:0] chan_c,
  input  logic [31:0] chan_d,
  input  logic        last_in,
  input  logic        result_valid,
  input  logic        result_ready,
  input  logic [31:0] out_a,
  input  logic [31:0] out_b,
  input  logic [31:0] out_c,
  input  logic [31:0] out_d,
  input  logic        last_out,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic        last;
  } texel_t;

  texel_t texels_due[$];

  logic [1:0] kind_q;
  logic [2:0] count_q;
  logic       swap_q;
  logic       depth_q;
  logic       pass_q;

  // Round a positive integer to 24 significant bits, nearest even
  function automatic logic [63:0] round_to_single(logic [63:0] v);
    int          msb;
    int          sh;
    logic [63:0] keep;
    logic [63:0] rem;
    logic [63:0] half;
    msb = 0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) msb = i;
    end
    if (msb < 24) return v;
    sh = msb - 23;
    keep = v >> sh;
    rem = v & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && keep[0])) keep = keep + 1;
    return keep << sh;
  endfunction

  // floor(mant * 2^e * scale) with the product rounded to single precision
  function automatic logic [31:0] scaled_floor(logic [63:0] mant, int e, logic [31:0] scale);
    logic [63:0] prod;
    prod = round_to_single(mant * {32'd0, scale});
    if (e >= 0) return 32'(prod << e);
    if (-e >= 64) return 32'd0;
    return 32'(prod >> (-e));
  endfunction

  function automatic logic [31:0] single_to_unorm(logic [31:0] w, logic [31:0] scale);
    if (w[30:23] == 8'hFF) begin
      if (w[22:0] != 0 || w[31]) return 32'd0;
      return scale;
    end
    if (w[31] || w[30:0] == 0) return 32'd0;
    if (w[30:0] > 31'h3F800000) return scale;
    if (w[30:23] == 0) return scaled_floor({41'd0, w[22:0]}, -149, scale);
    return scaled_floor({40'd0, 1'b1, w[22:0]}, int'(w[30:23]) - 150, scale);
  endfunction

  function automatic logic [31:0] half_to_unorm(logic [15:0] h, logic [31:0] scale);
    if (h[14:10] == 5'h1F) begin
      if (h[9:0] != 0 || h[15]) return 32'd0;
      return scale;
    end
    if (h[15] || h[14:0] == 0) return 32'd0;
    if (h[14:0] > 15'h3C00) return scale;
    if (h[14:10] == 0) return scaled_floor({54'd0, h[9:0]}, -24, scale);
    return scaled_floor({53'd0, 1'b1, h[9:0]}, int'(h[14:10]) - 25, scale);
  endfunction

  function automatic logic [31:0] color_lane(logic [31:0] w);
    case (kind_q)
      KIND_F32:  return single_to_unorm(w, UNORM8_MAX);
      KIND_F16:  return half_to_unorm(w[15:0], UNORM8_MAX);
      KIND_BYTE: return {24'd0, w[7:0]};
      default:   return 32'd0;
    endcase
  endfunction

  function automatic texel_t convert_texel(texel_t t);
    logic [31:0] src[4];
    logic [31:0] res[4];
    logic [31:0] tmp;
    int          n;
    texel_t      r;
    n = (count_q == 0) ? 1 : (count_q > 4) ? 4 : int'(count_q);
    src[0] = t.a;
    src[1] = t.b;
    src[2] = t.c;
    src[3] = t.d;
    for (int i = 0; i < 4; i++) res[i] = 32'd0;
    if (pass_q) begin
      for (int i = 0; i < n; i++) res[i] = src[i];
    end else if (depth_q) begin
      if (kind_q == KIND_F32) begin
        res[0] = single_to_unorm(src[0], UNORM16_MAX);
      end else if (kind_q == KIND_U32) begin
        // u32 / (2^32) is exact once the integer is rounded to single
        res[0] = scaled_floor(round_to_single({32'd0, src[0]}), -32, UNORM16_MAX);
      end
    end else begin
      if (swap_q && n >= 3) begin
        tmp = src[0];
        src[0] = src[2];
        src[2] = tmp;
      end
      for (int i = 0; i < n; i++) res[i] = color_lane(src[i]);
    end
    r.a = res[0];
    r.b = res[1];
    r.c = res[2];
    r.d = res[3];
    r.last = t.last;
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    texel_t want;
    if (rst) begin
      kind_q <= KIND_F32;
      count_q <= 3'd4;
      swap_q <= 1'b0;
      depth_q <= 1'b0;
      pass_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_SOURCE_KIND:   kind_q <= pwdata[1:0];
          REG_CHANNEL_COUNT: count_q <= pwdata[2:0];
          REG_SWAP_ORDER:    swap_q <= pwdata[0];
          REG_DEPTH_MODE:    depth_q <= pwdata[0];
          REG_PASS_THROUGH:  pass_q <= pwdata[0];
          default: ;
        endcase
      end
      if (texel_valid && texel_ready)
        texels_due.push_back(convert_texel('{chan_a, chan_b, chan_c, chan_d, last_in}));
      if (result_valid && result_ready) begin
        if (texels_due.size() == 0) begin
          $error("result word with nothing outstanding");
          errors++;
        end else begin
          want = texels_due.pop_front();
          compare_field("out_a", want.a, out_a);
          compare_field("out_b", want.b, out_b);
          compare_field("out_c", want.c, out_c);
          compare_field("out_d", want.d, out_d);
          compare_field("last_out", {31'd0, want.last}, {31'd0, last_out});
        end
      end
    end
    pending = texels_due.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tfc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 16;
  localparam int WORDS_PER_PHASE = 70;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        texel_valid;
  logic        texel_ready;
  logic [31:0] chan_a;
  logic [31:0] chan_b;
  logic [31:0] chan_c;
  logic [31:0] chan_d;
  logic        last_in;
  logic        result_valid;
  logic        result_ready;
  logic [31:0] out_a;
  logic [31:0] out_b;
  logic [31:0] out_c;
  logic [31:0] out_d;
  logic        last_out;

  int   errors;
  int   pending;
  int   cycles;
  logic word_taken;   // input handshake seen at the last rising edge
  logic calm;         // no idling on either side
  logic hold_req;     // ask the receiver for a long hold-off
  logic [1:0] kind_now;

  texel_format_converter uut (.*);

  tfc_checker check (.*);

  // Clock: 2 ns period
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Watchdog: give up well past the slowest legal run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Latch acceptance so the sender never races the block at the edge
  always @(posedge clk) word_taken <= texel_valid && texel_ready;

  // Receiver: stall at random, hold off for a long stretch on request
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      result_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Offer one word; idle first at random, hold it until taken
  task automatic send_word(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] d, logic last);
    while (!calm && $urandom_range(99) < 38) begin
      texel_valid <= 1'b0;
      @(negedge clk);
    end
    texel_valid <= 1'b1;
    chan_a <= a;
    chan_b <= b;
    chan_c <= c;
    chan_d <= d;
    last_in <= last;
    do @(negedge clk); while (!word_taken);
  endtask

  // Drain the three-stage pipe: stop sending, wait until nothing is outstanding
  task automatic wait_idle();
    texel_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic logic [31:0] single_word();
    logic [31:0] specials[10] = '{32'h00000000, 32'h80000000, 32'h3F800000, 32'h7F800000,
                                  32'hFF800000, 32'h7FC00000, 32'h00000001, 32'h3F7FFFFF,
                                  32'h7F7FFFFF, 32'hBF800000};
    case ($urandom_range(9))
      0, 1, 2, 3: return {1'b0, 8'($urandom_range(100, 127)), 23'($urandom)};
      4:          return specials[$urandom_range(9)];
      5:          return {1'($urandom_range(1)), 8'd0, 23'($urandom)};
      6:          return {1'b1, 8'($urandom_range(100, 127)), 23'($urandom)};
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] half_word();
    logic [15:0] specials[10] = '{16'h0000, 16'h8000, 16'h3C00, 16'h7C00, 16'hFC00,
                                  16'h7E00, 16'h0001, 16'h3BFF, 16'h03FF, 16'h7BFF};
    logic [15:0] h;
    case ($urandom_range(9))
      0, 1, 2, 3: h = {1'b0, 5'($urandom_range(0, 15)), 10'($urandom)};
      4:          h = specials[$urandom_range(9)];
      5:          h = {1'b0, 5'd0, 10'($urandom)};
      default:    h = 16'($urandom);
    endcase
    return {16'($urandom), h};
  endfunction

  function automatic logic [31:0] wide_word();
    case ($urandom_range(5))
      0:       return $urandom_range(0, 32'h01FFFFFF);
      1:       return 32'hFFFFFFFF - $urandom_range(0, 255);
      2:       return 32'h01000000 + $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] chan_word();
    case (kind_now)
      KIND_F32: return single_word();
      KIND_F16: return half_word();
      default:  return ($urandom_range(3) == 0) ? wide_word() : $urandom;
    endcase
  endfunction

  task automatic set_mode(logic [1:0] kind, logic [2:0] count, logic swap, logic depth,
                          logic pass);
    reg_write(REG_SOURCE_KIND, {30'd0, kind});
    reg_write(REG_CHANNEL_COUNT, {29'd0, count});
    reg_write(REG_SWAP_ORDER, {31'd0, swap});
    reg_write(REG_DEPTH_MODE, {31'd0, depth});
    reg_write(REG_PASS_THROUGH, {31'd0, pass});
    kind_now = kind;
  endtask

  initial begin
    logic [1:0]  kinds[PHASES]  = '{KIND_F32, KIND_F16, KIND_F16, KIND_BYTE, KIND_U32,
                                    KIND_F32, KIND_U32, KIND_F16, KIND_BYTE, KIND_F32,
                                    KIND_F16, KIND_F32, KIND_U32, KIND_BYTE, KIND_F32,
                                    KIND_F16};
    logic [2:0]  counts[PHASES] = '{3'd4, 3'd4, 3'd3, 3'd4, 3'd2, 3'd1, 3'd4, 3'd4,
                                    3'd0, 3'd7, 3'd5, 3'd2, 3'd3, 3'd6, 3'd4, 3'd1};
    logic        swaps[PHASES]  = '{0, 1, 1, 1, 0, 0, 0, 0, 1, 1, 0, 1, 1, 0, 1, 1};
    logic        depths[PHASES] = '{0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 1, 0, 1, 1, 1, 0};
    logic        passes[PHASES] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 1, 0};
    logic [31:0] edge_vals[10]  = '{32'h00000000, 32'h80000000, 32'h3F800000, 32'h7F800000,
                                    32'hFF800000, 32'h7FC00000, 32'h00000001, 32'h3F7FFFFF,
                                    32'h7F7FFFFF, 32'hFFFFFFFF};

    // Hold every input at a known value through reset
    cycles = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    kind_now = KIND_F32;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    texel_valid = 1'b0;
    chan_a = '0;
    chan_b = '0;
    chan_c = '0;
    chan_d = '0;
    last_in = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset mode (float32 color, four channels), edge values rotated
    for (int i = 0; i < 10; i++)
      send_word(edge_vals[i], edge_vals[(i + 3) % 10], edge_vals[(i + 6) % 10],
                edge_vals[(i + 9) % 10], i[0]);
    // Half-float corners in the low half, junk in the high half
    wait_idle();
    set_mode(KIND_F16, 3'd4, 1'b1, 1'b0, 1'b0);
    send_word(32'hFFFF3C00, 32'h00007C00, 32'hABCD0001, 32'h0000FE00, 1'b1);
    send_word(32'h000003FF, 32'h12343BFF, 32'h00008000, 32'h00007BFF, 1'b0);
    // Depth corners for uint32
    wait_idle();
    set_mode(KIND_U32, 3'd4, 1'b0, 1'b1, 1'b0);
    send_word(32'hFFFFFFFF, 32'h1, 32'h2, 32'h3, 1'b1);
    send_word(32'h00000000, 32'h1, 32'h2, 32'h3, 1'b0);
    send_word(32'h80000000, 32'h1, 32'h2, 32'h3, 1'b1);
    send_word(32'h01000001, 32'h1, 32'h2, 32'h3, 1'b0);
    wait_idle();

    // Random phases, each with its own mode
    for (int p = 0; p < PHASES; p++) begin
      set_mode(kinds[p], counts[p], swaps[p], depths[p], passes[p]);
      calm = (p == 5);
      if (p == 3) hold_req = 1'b1;
      for (int i = 0; i < WORDS_PER_PHASE; i++)
        send_word(chan_word(), chan_word(), chan_word(), chan_word(), 1'($urandom));
      wait_idle();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
